/* hdl/rfs_pkg.sv */
`timescale 1ns / 1ps

package rfs_pkg;

  // Fixed field widths
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned RB_W      = 4;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 11;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECORD_BYTES = 1'b0,
    REG_ENTRY_COUNT  = 1'b1
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic load_we;   // write the load word into the table
    logic start;     // latch key and initial bounds
    logic issue;     // read the midpoint record
    logic narrow;    // move one bound after a mismatch
    logic res_hit;   // result: found at midpoint
    logic res_miss;  // result: not found / load
    logic out_load;  // move pending result to output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;     // search range exhausted
    logic rec_eq;    // probed record equals key
  } ctrl_sts_t;

  // Byte mask over the low nb bytes of a 64-bit word
  function automatic logic [VAL_W-1:0] byte_mask(input logic [RB_W-1:0] nb);
    logic [VAL_W-1:0] m;
    m = '0;
    for (int i = 0; i < VAL_W / 8; i++) begin
      if (RB_W'(i) < nb) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* hdl/rfs_if.sv */
`timescale 1ns / 1ps

interface rfs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [rfs_pkg::IDX_W-1:0]      record_index;
  logic [rfs_pkg::VAL_W-1:0]      record_value;
  logic [rfs_pkg::VAL_W-1:0]      key;

  modport source (output valid, output command, output record_index,
                  output record_value, output key, input ready);
  modport sink   (input valid, input command, input record_index,
                  input record_value, input key, output ready);
endinterface

interface rfs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [rfs_pkg::IDX_W-1:0]      match_index;

  modport source (output valid, output found, output match_index, input ready);
  modport sink   (input valid, input found, input match_index, output ready);
endinterface

/* hdl/rfs_ram.sv */
`timescale 1ns / 1ps

module rfs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rfs_datapath.sv */
`timescale 1ns / 1ps

module rfs_datapath #(
  parameter int unsigned MAX_ENTRIES      = 1024,
  parameter int unsigned MAX_RECORD_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rfs_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  rfs_pkg::ctrl_cmd_t                cmd_i,
  output rfs_pkg::ctrl_sts_t                sts_o,
  input  logic [rfs_pkg::IDX_W-1:0]         record_index_i,
  input  logic [rfs_pkg::VAL_W-1:0]         record_value_i,
  input  logic [rfs_pkg::VAL_W-1:0]         key_i,
  output logic                              found_o,
  output logic [rfs_pkg::IDX_W-1:0]         match_index_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RW = 8 * MAX_RECORD_BYTES;

  // Configuration registers
  logic [rfs_pkg::RB_W-1:0]  rb_q;
  logic [rfs_pkg::CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q  <= rfs_pkg::RB_W'(2);
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rfs_pkg::cfg_reg_e'(cfg_idx_i))
        rfs_pkg::REG_RECORD_BYTES: rb_q  <= cfg_data_i[rfs_pkg::RB_W-1:0];
        rfs_pkg::REG_ENTRY_COUNT:  cnt_q <= cfg_data_i[rfs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective width and count
  logic [rfs_pkg::RB_W-1:0]  nb_eff;
  logic [rfs_pkg::VAL_W-1:0] mask_full;
  logic [RW-1:0]             mask_d;
  logic [16:0]               cnt_ext;
  logic [16:0]               cnt_clamp;

  always_comb begin
    priority if (rb_q == '0) begin
      nb_eff = rfs_pkg::RB_W'(1);
    end else if (rb_q > rfs_pkg::RB_W'(MAX_RECORD_BYTES)) begin
      nb_eff = rfs_pkg::RB_W'(MAX_RECORD_BYTES);
    end else begin
      nb_eff = rb_q;
    end
  end

  assign mask_full = rfs_pkg::byte_mask(nb_eff);
  assign mask_d    = mask_full[RW-1:0];
  assign cnt_ext   = 17'(cnt_q);
  assign cnt_clamp = (cnt_ext > 17'(MAX_ENTRIES)) ? 17'(MAX_ENTRIES) : cnt_ext;

  // Search registers; rend_q is one past the right bound
  logic [RW-1:0] key_q;
  logic [RW-1:0] mask_q;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] rend_q, rend_d;
  logic [AW-1:0] mid_q;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid;

  assign mid_sum = {1'b0, left_q} + {1'b0, rend_q} - (CW+1)'(1);
  assign mid     = mid_sum[AW:1];

  // Table
  logic [16:0]   widx;
  logic          wr_en;
  logic [RW-1:0] rdata;
  logic [RW-1:0] rec;

  assign widx  = 17'(record_index_i);
  assign wr_en = cmd_i.load_we && (widx < 17'(MAX_ENTRIES));

  rfs_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (widx[AW-1:0]),
    .wdata_i (record_value_i[RW-1:0]),
    .re_i    (cmd_i.issue),
    .raddr_i (mid),
    .rdata_o (rdata)
  );

  assign rec          = rdata & mask_q;
  assign sts_o.rec_eq = (rec == key_q);
  assign sts_o.empty  = (left_q >= rend_q);

  always_comb begin
    left_d = left_q;
    rend_d = rend_q;
    if (cmd_i.start) begin
      left_d = '0;
      rend_d = cnt_clamp[CW-1:0];
    end else if (cmd_i.narrow) begin
      if (rec > key_q) begin
        rend_d = CW'(mid_q);
      end else begin
        left_d = CW'(mid_q) + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    rend_q <= rend_d;
    if (cmd_i.start) begin
      key_q  <= key_i[RW-1:0] & mask_d;
      mask_q <= mask_d;
    end
    if (cmd_i.issue) begin
      mid_q <= mid;
    end
  end

  // Pending result and output word
  logic                      res_found_q;
  logic [rfs_pkg::IDX_W-1:0] res_idx_q;
  logic                      out_found_q;
  logic [rfs_pkg::IDX_W-1:0] out_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_hit) begin
      res_found_q <= 1'b1;
      res_idx_q   <= rfs_pkg::IDX_W'(mid_q);
    end else if (cmd_i.res_miss) begin
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
    end
    if (cmd_i.out_load) begin
      out_found_q <= res_found_q;
      out_idx_q   <= res_idx_q;
    end
  end

  assign found_o       = out_found_q;
  assign match_index_o = out_idx_q;

endmodule

/* hdl/rfs_ctrl.sv */
`timescale 1ns / 1ps

module rfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_command_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rfs_pkg::ctrl_cmd_t cmd_o,
  input  rfs_pkg::ctrl_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_command_i == rfs_pkg::CMD_LOAD) begin
            cmd_o.load_we  = 1'b1;
            cmd_o.res_miss = 1'b1;
            state_d        = ST_RESULT;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (sts_i.empty) begin
          cmd_o.res_miss = 1'b1;
          state_d        = ST_RESULT;
        end else begin
          cmd_o.issue = 1'b1;
          state_d     = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts_i.rec_eq) begin
          cmd_o.res_hit = 1'b1;
          state_d       = ST_RESULT;
        end else begin
          cmd_o.narrow = 1'b1;
          state_d      = ST_ISSUE;
        end
      end
      ST_RESULT: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/fixed_record_binary_search.sv */
`timescale 1ns / 1ps

// Sorted fixed-record table with binary search. A load word (command 0) writes
// record_value into entry record_index and returns found 0, match index 0. A
// search word (command 1) binary-searches the first entry_count records for
// key, comparing the low record_bytes bytes as unsigned values, and returns
// found and the matching index. Each probe reads the table's single registered
// read port and then compares and moves a bound; with n entries a search makes
// at most floor(log2 n) + 1 probes. One word is in work at a time; a new word
// is taken while the previous result still waits in the output register.
// Registers: index 0 record_bytes (reset 2), index 1 entry_count (reset 0); write
// them only while the block is idle. Records that a search may probe must have
// been loaded first.
module fixed_record_binary_search #(
  parameter int unsigned MAX_ENTRIES      = 1024,
  parameter int unsigned MAX_RECORD_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rfs_pkg::CFG_DAT_W-1:0] cfg_data_i,
  rfs_in_if.sink                        in_i,
  rfs_out_if.source                     out_o
);

  rfs_pkg::ctrl_cmd_t cmd;
  rfs_pkg::ctrl_sts_t sts;
  logic               in_ready;
  logic               out_valid;

  rfs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  rfs_datapath #(
    .MAX_ENTRIES      (MAX_ENTRIES),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .record_index_i (in_i.record_index),
    .record_value_i (in_i.record_value),
    .key_i          (in_i.key),
    .found_o        (out_o.found),
    .match_index_o  (out_o.match_index)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

`ifndef SYNTH
  // one word at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("word accepted while previous one still in work");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("output word overwritten before it was taken");

  // no table read once the range is exhausted
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !sts.empty)
    else $error("probe issued on an empty search range");
`endif

endmodule

/* test/rfs_lookup_checker.sv */
`timescale 1ns / 1ps

module rfs_lookup_checker #(
  parameter int unsigned ENTRIES   = 1024,
  parameter int unsigned MAX_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rfs_pkg::CFG_DAT_W-1:0] cfg_data_i,
  rfs_in_if                             in_i,
  rfs_out_if                            rsp_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic                      found;
    logic [rfs_pkg::IDX_W-1:0] match_index;
  } lookup_t;

  logic [rfs_pkg::VAL_W-1:0] stored_words [ENTRIES];
  logic [rfs_pkg::RB_W-1:0]  width_reg;
  logic [rfs_pkg::CNT_W-1:0] count_reg;
  lookup_t                   expected_q [$];
  int                        fails = 0;

  // Binary search over the first count_reg words, low width_reg bytes only
  function automatic lookup_t lookup_key(input logic [rfs_pkg::VAL_W-1:0] probe);
    logic [rfs_pkg::VAL_W-1:0] cmp_mask;
    logic [rfs_pkg::VAL_W-1:0] want;
    logic [rfs_pkg::VAL_W-1:0] rec;
    int                        nb;
    int                        n;
    int                        lo;
    int                        hi;
    int                        mid;
    bit                        hit;
    lookup_t                   res;
    res = '0;
    hit = 1'b0;
    nb  = int'(width_reg);
    if (nb < 1) nb = 1;
    if (nb > int'(MAX_BYTES)) nb = int'(MAX_BYTES);
    cmp_mask = (nb >= 8) ? {rfs_pkg::VAL_W{1'b1}} : ((64'd1 << (8 * nb)) - 64'd1);
    want = probe & cmp_mask;
    n = int'(count_reg);
    if (n > int'(ENTRIES)) n = int'(ENTRIES);
    lo = 0;
    hi = n - 1;
    while (!hit && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      rec = stored_words[mid] & cmp_mask;
      if (rec > want) begin
        hi = mid - 1;
      end else if (rec < want) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
        res.found = 1'b1;
        res.match_index = rfs_pkg::IDX_W'(mid);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    lookup_t want;
    if (!rst_ni) begin
      width_reg = rfs_pkg::RB_W'(2);
      count_reg = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (rfs_pkg::cfg_reg_e'(cfg_idx_i))
          rfs_pkg::REG_RECORD_BYTES: width_reg = cfg_data_i[rfs_pkg::RB_W-1:0];
          rfs_pkg::REG_ENTRY_COUNT:  count_reg = cfg_data_i[rfs_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      // result side first: a word taken this edge cannot answer this edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing pending: found %0b match_index %0d",
                 rsp_i.found, rsp_i.match_index);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, rsp_i.found);
            fails++;
          end
          if (rsp_i.match_index !== want.match_index) begin
            $error("match_index: expected %0d, actual %0d",
                   want.match_index, rsp_i.match_index);
            fails++;
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        if (in_i.command == rfs_pkg::CMD_LOAD) begin
          if (int'(in_i.record_index) < int'(ENTRIES)) begin
            stored_words[in_i.record_index] = in_i.record_value;
          end
          expected_q.push_back('0);
        end else begin
          expected_q.push_back(lookup_key(in_i.key));
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
  end

endmodule

/* test/tb_fixed_record_binary_search.sv */
`timescale 1ns / 1ps

module tb_fixed_record_binary_search;

  localparam int ENTRIES      = 1024;
  localparam int MAX_BYTES    = 8;
  localparam int LONG_HOLD    = 150;
  localparam int RUN_LIMIT_NS = 10_000_000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we;
  rfs_pkg::cfg_reg_e             cfg_idx;
  logic [rfs_pkg::CFG_DAT_W-1:0] cfg_data;
  int                            fail_count;
  int                            results_due;
  int                            hold_asked = 0;

  // what the table holds, so that searches can aim at stored records
  logic [rfs_pkg::VAL_W-1:0]     shadow_val [ENTRIES];

  rfs_in_if  req_bus ();
  rfs_out_if rsp_bus ();

  fixed_record_binary_search #(
    .MAX_ENTRIES      (ENTRIES),
    .MAX_RECORD_BYTES (MAX_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_bus),
    .out_o      (rsp_bus)
  );

  rfs_lookup_checker #(
    .ENTRIES   (ENTRIES),
    .MAX_BYTES (MAX_BYTES)
  ) lookup_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_i         (req_bus),
    .rsp_i        (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (results_due)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [rfs_pkg::VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly back to back, sometimes short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [rfs_pkg::VAL_W-1:0] mask_for(input int rb);
    int nb;
    nb = (rb < 1) ? 1 : (rb > MAX_BYTES) ? MAX_BYTES : rb;
    return (nb >= 8) ? {rfs_pkg::VAL_W{1'b1}} : ((64'd1 << (8 * nb)) - 64'd1);
  endfunction

  task automatic send_word(input logic cmd, input logic [rfs_pkg::IDX_W-1:0] idx,
                           input logic [rfs_pkg::VAL_W-1:0] val,
                           input logic [rfs_pkg::VAL_W-1:0] probe);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.command      <= cmd;
    req_bus.record_index <= idx;
    req_bus.record_value <= val;
    req_bus.key          <= probe;
    do @(posedge clk_i); while (!req_bus.ready);
    if (cmd == rfs_pkg::CMD_LOAD) shadow_val[idx] = val;
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input int rb, input int cnt);
    cfg_we   <= 1'b1;
    cfg_idx  <= rfs_pkg::REG_RECORD_BYTES;
    cfg_data <= rfs_pkg::CFG_DAT_W'(rb);
    @(posedge clk_i);
    cfg_idx  <= rfs_pkg::REG_ENTRY_COUNT;
    cfg_data <= rfs_pkg::CFG_DAT_W'(cnt);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // entries 0..n-1, non-decreasing in the compared bytes (random when not ordered), random bytes above
  task automatic load_sorted(input int n, input logic [rfs_pkg::VAL_W-1:0] cmp_mask,
                             input bit ordered);
    logic [rfs_pkg::VAL_W-1:0] level;
    logic [rfs_pkg::VAL_W-1:0] step;
    level = '0;
    step  = cmp_mask / rfs_pkg::VAL_W'(n + 1);
    for (int i = 0; i < n; i++) begin
      if (ordered) begin
        level = level + rand64() % (step + 64'd1);
        send_word(rfs_pkg::CMD_LOAD, rfs_pkg::IDX_W'(i),
                  (level & cmp_mask) | (rand64() & ~cmp_mask), rand64());
      end else begin
        send_word(rfs_pkg::CMD_LOAD, rfs_pkg::IDX_W'(i), rand64(), rand64());
      end
    end
  endtask

  task automatic search_round(input int tries, input int n,
                              input logic [rfs_pkg::VAL_W-1:0] cmp_mask);
    int                        roll;
    int                        pick;
    logic [rfs_pkg::VAL_W-1:0] probe;
    for (int t = 0; t < tries; t++) begin
      roll  = $urandom_range(0, 99);
      pick  = (n > 0) ? $urandom_range(0, n - 1) : 0;
      probe = rand64();
      if (n > 0 && roll < 55) begin
        probe = (shadow_val[pick] & cmp_mask) | (probe & ~cmp_mask);
      end else if (n > 0 && roll < 65) begin
        probe = (shadow_val[pick] & cmp_mask) + 64'd1;
      end else if (n > 0 && roll < 75) begin
        probe = (shadow_val[pick] & cmp_mask) - 64'd1;
      end
      // a stray load now and then upsets the ordering
      if (roll >= 90) begin
        send_word(rfs_pkg::CMD_LOAD, rfs_pkg::IDX_W'($urandom_range(0, ENTRIES - 1)),
                  rand64(), rand64());
      end else begin
        send_word(rfs_pkg::CMD_SEARCH, rfs_pkg::IDX_W'($urandom), rand64(), probe);
      end
    end
  endtask

  // keys at or below the left-hand path records only ever probe that path
  task automatic path_round();
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, '0);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'd17);
    for (int k = 0; k < $clog2(ENTRIES); k++) begin
      send_word(rfs_pkg::CMD_SEARCH, '0, '0, rfs_pkg::VAL_W'(16 * (k + 1)));
    end
  endtask

  initial begin : result_pacing
    int span;
    int served;
    served = 0;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (served != hold_asked) begin
        served = hold_asked;
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if ($urandom_range(0, 1) == 1) begin
        rsp_bus.ready <= 1'b1;
        span = $urandom_range(0, 24);
        repeat (span) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b0;
        span = gap_len();
        repeat (span) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [rfs_pkg::VAL_W-1:0] seed_words [6];
    logic [rfs_pkg::VAL_W-1:0] cmp_mask;
    int                        rb;
    int                        n;
    seed_words[0] = 64'hFFFF_FFFF_FFFF_0000;
    seed_words[1] = 64'h0000_0000_0000_0001;
    seed_words[2] = 64'h5A5A_0000_0000_1234;
    seed_words[3] = 64'h0000_0000_0000_1234;
    seed_words[4] = 64'h0123_4567_89AB_8000;
    seed_words[5] = 64'h0000_0000_0000_FFFF;

    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = rfs_pkg::REG_RECORD_BYTES;
    cfg_data             = '0;
    req_bus.valid        = 1'b0;
    req_bus.command      = rfs_pkg::CMD_LOAD;
    req_bus.record_index = '0;
    req_bus.record_value = '0;
    req_bus.key          = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table straight out of reset
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, '0);
    send_word(rfs_pkg::CMD_SEARCH, '1, '1, '1);
    send_word(rfs_pkg::CMD_LOAD, rfs_pkg::IDX_W'(ENTRIES - 1), '1, '0);
    for (int i = 0; i < 6; i++) begin
      send_word(rfs_pkg::CMD_LOAD, rfs_pkg::IDX_W'(i), seed_words[i], '1);
    end
    settle();
    set_config(2, 6);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'h0);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'hABCD_0000);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'h1);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'hFFFF_0000_0000_1234);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'h8000);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'hFFFF);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'h1235);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'h7FFF);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    // zero width acts as one byte, oversize as the full word
    settle();
    set_config(0, 6);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'h34);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'hFF);
    settle();
    set_config(15, 6);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, 64'h0123_4567_89AB_8000);
    send_word(rfs_pkg::CMD_SEARCH, '0, '0, '1);
    settle();

    for (int p = 0; p < 12; p++) begin
      rb = (p == 0) ? 1 : (p == 1) ? 8 :
           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      n  = (p == 2) ? 0 : (p == 3) ? 1 : $urandom_range(2, 32);
      cmp_mask = mask_for(rb);
      if (p == 0) hold_asked <= hold_asked + 1;
      load_sorted(n, cmp_mask, $urandom_range(0, 7) != 0);
      settle();
      set_config(rb, n);
      search_round($urandom_range(16, 28), n, cmp_mask);
      settle();
    end

    // ascending records on the left-hand probe path of a full table (entries
    // 0, 1, 3, 7 .. ENTRIES/2 - 1), then a full count and a count past the end
    hold_asked <= hold_asked + 1;
    for (int k = 0; k < $clog2(ENTRIES); k++) begin
      send_word(rfs_pkg::CMD_LOAD, rfs_pkg::IDX_W'((1 << k) - 1),
                rfs_pkg::VAL_W'(16 * (k + 1)), rand64());
    end
    settle();
    set_config(8, ENTRIES);
    path_round();
    settle();
    set_config(8, 2047);
    path_round();
    settle();
    repeat (30) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

/* fixed_record_binary_search.f */
hdl/rfs_pkg.sv
hdl/rfs_if.sv
hdl/rfs_ram.sv
hdl/rfs_datapath.sv
hdl/rfs_ctrl.sv
hdl/fixed_record_binary_search.sv
test/rfs_lookup_checker.sv
test/tb_fixed_record_binary_search.sv
